### sv/msf_pkg.sv
// Shared types, constants and saturation helpers for the mass-spring force step.
`timescale 1ns / 1ps

package msf_pkg;

  typedef enum logic [1:0] {
    REG_SPRING_GAIN  = 2'd0,
    REG_DAMPING_GAIN = 2'd1,
    REG_REST_LENGTH  = 2'd2,
    REG_MIN_LENGTH   = 2'd3
  } cfg_reg_t;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned GainW = 31;
  localparam int unsigned MinW = 16;

  // Division of the rest length by ten through a reciprocal multiply.
  localparam logic [31:0] RecipTen = 32'hCCCC_CCCD;
  localparam int unsigned RecipShift = 35;
  localparam int unsigned BoundW = 28;

  localparam int unsigned SqSteps = 32;
  localparam int unsigned QuoW = 33;
  localparam int unsigned DivLanes = 6;
  localparam int unsigned FifoDepth = 2;

  typedef logic [2:0][31:0] vec3_t;

  typedef struct packed {
    vec3_t sep;
    vec3_t damp_a;
    vec3_t damp_b;
    logic  pinned_a;
    logic  pinned_b;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [63:0] sum;
  } item_t;

  typedef struct packed {
    vec3_t force_a;
    vec3_t force_b;
    vec3_t move_a;
    vec3_t move_b;
  } result_t;

  function automatic logic [31:0] sat_mag(input logic [63:0] mag, input logic neg);
    logic [31:0] res;
    if (neg) begin
      if (mag >= 64'h8000_0000) res = 32'h8000_0000;
      else res = 32'd0 - mag[31:0];
    end else begin
      if (mag >= 64'h7FFF_FFFF) res = 32'h7FFF_FFFF;
      else res = mag[31:0];
    end
    return res;
  endfunction

  function automatic logic [31:0] sat_sum(input logic [32:0] v);
    logic [31:0] res;
    if (v[32] != v[31]) res = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else res = v[31:0];
    return res;
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

### sv/msf_fifo.sv
// Small register queue between the front and back halves.
`timescale 1ns / 1ps

module msf_fifo #(
  parameter int W = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [W-1:0] mem [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic do_push, do_pop;

  assign full = (count == CntW'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wdata;
  end

endmodule

### sv/msf_front.sv
// Front half: takes input transactions, squares the separation and forms damping forces.
`timescale 1ns / 1ps

module msf_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  msf_pkg::vec3_t                sep,
  input  msf_pkg::vec3_t                vel_a,
  input  msf_pkg::vec3_t                vel_b,
  input  logic                          pinned_a,
  input  logic                          pinned_b,
  input  logic [msf_pkg::GainW-1:0]     damping_gain,
  output logic                          push,
  output msf_pkg::item_t                item,
  input  logic                          room
);
  logic a_valid;
  logic take;
  msf_pkg::vec3_t sep_r;
  msf_pkg::vec3_t sep_mag, va_mag, vb_mag;
  logic [2:0][63:0] sq_r;
  logic [2:0][62:0] dpa_r, dpb_r;
  logic [2:0] pos_a_r, pos_b_r;
  logic pa_r, pb_r;

  assign in_ready = !a_valid || room;
  assign take = in_valid && in_ready;
  assign push = a_valid;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sep_mag[i] = msf_pkg::abs32(sep[i]);
      va_mag[i] = msf_pkg::abs32(vel_a[i]);
      vb_mag[i] = msf_pkg::abs32(vel_b[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (take) begin
      a_valid <= 1'b1;
    end else if (room) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sep_r <= sep;
      pa_r <= pinned_a;
      pb_r <= pinned_b;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= 64'(sep_mag[i]) * 64'(sep_mag[i]);
        dpa_r[i] <= 63'(damping_gain) * 63'(va_mag[i]);
        dpb_r[i] <= 63'(damping_gain) * 63'(vb_mag[i]);
        pos_a_r[i] <= !vel_a[i][31] && (vel_a[i] != '0);
        pos_b_r[i] <= !vel_b[i][31] && (vel_b[i] != '0);
      end
    end
  end

  always_comb begin
    item.side.sep = sep_r;
    item.side.pinned_a = pa_r;
    item.side.pinned_b = pb_r;
    item.sum = sq_r[0] + sq_r[1] + sq_r[2];
    for (int i = 0; i < 3; i++) begin
      item.side.damp_a[i] = msf_pkg::sat_mag(
        (64'(dpa_r[i]) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS, pos_a_r[i]);
      item.side.damp_b[i] = msf_pkg::sat_mag(
        (64'(dpb_r[i]) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS, pos_b_r[i]);
    end
  end

endmodule

### sv/msf_div.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes sharing a divisor.
`timescale 1ns / 1ps

module msf_div #(
  parameter int LANES = 6,
  parameter int SIDE_W = 8,
  parameter int NUM_W = 64,
  parameter int DEN_W = 32,
  parameter int QUO_W = 33
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [SIDE_W-1:0]            in_side,
  input  logic [LANES-1:0][NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]             den,
  output logic                         out_valid,
  output logic [SIDE_W-1:0]            out_side,
  output logic [DEN_W-1:0]             out_den,
  output logic [LANES-1:0][QUO_W-1:0]  quo,
  output logic [LANES-1:0][DEN_W-1:0]  rem
);
  logic [QUO_W-1:0] vld;
  logic [SIDE_W-1:0] side_s [QUO_W];
  logic [DEN_W-1:0] den_s [QUO_W];
  logic [DEN_W-1:0] den_p [QUO_W];
  logic [LANES-1:0][DEN_W-1:0] rem_s [QUO_W];
  logic [LANES-1:0][DEN_W-1:0] rem_p [QUO_W];
  logic [LANES-1:0][DEN_W-1:0] rem_n [QUO_W];
  logic [LANES-1:0][QUO_W-1:0] low_s [QUO_W];
  logic [LANES-1:0][QUO_W-1:0] low_p [QUO_W];
  logic [LANES-1:0][QUO_W-1:0] quo_s [QUO_W];
  logic [LANES-1:0][QUO_W-1:0] quo_p [QUO_W];
  logic [LANES-1:0][QUO_W-1:0] quo_n [QUO_W];
  logic [LANES-1:0][DEN_W:0] trial [QUO_W];
  logic [LANES-1:0] fits [QUO_W];

  always_comb begin
    den_p[0] = den;
    for (int l = 0; l < LANES; l++) begin
      rem_p[0][l] = DEN_W'(num[l][NUM_W-1:QUO_W]);
      low_p[0][l] = num[l][QUO_W-1:0];
      quo_p[0][l] = '0;
    end
    for (int s = 1; s < QUO_W; s++) begin
      den_p[s] = den_s[s-1];
      rem_p[s] = rem_s[s-1];
      low_p[s] = low_s[s-1];
      quo_p[s] = quo_s[s-1];
    end
    for (int s = 0; s < QUO_W; s++) begin
      for (int l = 0; l < LANES; l++) begin
        trial[s][l] = {rem_p[s][l], low_p[s][l][QUO_W-1]};
        fits[s][l] = trial[s][l] >= {1'b0, den_p[s]};
        rem_n[s][l] = fits[s][l] ? DEN_W'(trial[s][l] - {1'b0, den_p[s]})
                                 : DEN_W'(trial[s][l]);
        quo_n[s][l] = {quo_p[s][l][QUO_W-2:0], fits[s][l]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QUO_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_s[0] <= in_side;
      for (int s = 1; s < QUO_W; s++) begin
        side_s[s] <= side_s[s-1];
      end
      for (int s = 0; s < QUO_W; s++) begin
        den_s[s] <= den_p[s];
        rem_s[s] <= rem_n[s];
        quo_s[s] <= quo_n[s];
        for (int l = 0; l < LANES; l++) begin
          low_s[s][l] <= low_p[s][l] << 1;
        end
      end
    end
  end

  assign out_valid = vld[QUO_W-1];
  assign out_side = side_s[QUO_W-1];
  assign out_den = den_s[QUO_W-1];
  assign quo = quo_s[QUO_W-1];
  assign rem = rem_s[QUO_W-1];

endmodule

### sv/msf_back.sv
// Back half: length by square root, stretch clamp, spring and correction division, results.
`timescale 1ns / 1ps

module msf_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  msf_pkg::item_t             q_item,
  output logic                       q_pop,
  input  logic [msf_pkg::GainW-1:0]  spring_gain,
  input  logic [msf_pkg::GainW-1:0]  rest_length,
  input  logic [msf_pkg::MinW-1:0]   min_length,
  output logic                       out_valid,
  input  logic                       out_ready,
  output msf_pkg::result_t           result
);
  localparam int SqSteps = msf_pkg::SqSteps;
  localparam int BoundW = msf_pkg::BoundW;

  typedef struct packed {
    msf_pkg::vec3_t damp_a;
    msf_pkg::vec3_t damp_b;
    logic [2:0]     sep_neg;
    logic [2:0]     sep_zero;
    logic           s_neg;
    logic           stretch_neg;
    logic           dzero;
    logic           short_len;
    logic           pinned_a;
    logic           pinned_b;
  } bside_t;

  logic adv;
  assign adv = !out_valid || out_ready;
  assign q_pop = adv && q_valid;

  // Square root, one result bit per stage.
  logic [SqSteps-1:0] sq_vld;
  msf_pkg::side_t sq_side [SqSteps];
  logic [63:0] sq_v [SqSteps];
  logic [63:0] sq_r [SqSteps];
  logic [63:0] sq_vp [SqSteps];
  logic [63:0] sq_rp [SqSteps];
  logic [63:0] sq_vn [SqSteps];
  logic [63:0] sq_rn [SqSteps];
  logic [63:0] sq_t [SqSteps];
  logic [63:0] sq_bit [SqSteps];

  always_comb begin
    sq_vp[0] = q_item.sum;
    sq_rp[0] = '0;
    for (int s = 1; s < SqSteps; s++) begin
      sq_vp[s] = sq_v[s-1];
      sq_rp[s] = sq_r[s-1];
    end
    for (int s = 0; s < SqSteps; s++) begin
      sq_bit[s] = 64'd1 << (62 - 2 * s);
      sq_t[s] = sq_rp[s] + sq_bit[s];
      if (sq_vp[s] >= sq_t[s]) begin
        sq_vn[s] = sq_vp[s] - sq_t[s];
        sq_rn[s] = (sq_rp[s] >> 1) + sq_bit[s];
      end else begin
        sq_vn[s] = sq_vp[s];
        sq_rn[s] = sq_rp[s] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld <= '0;
    end else if (adv) begin
      sq_vld <= {sq_vld[SqSteps-2:0], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_side[0] <= q_item.side;
      for (int s = 1; s < SqSteps; s++) begin
        sq_side[s] <= sq_side[s-1];
      end
      for (int s = 0; s < SqSteps; s++) begin
        sq_v[s] <= sq_vn[s];
        sq_r[s] <= sq_rn[s];
      end
    end
  end

  // Clamp bound, one tenth of the rest length.
  logic [62:0] rest_prod;
  logic [BoundW-1:0] bound;
  always_ff @(posedge clk) begin
    rest_prod <= 63'(rest_length) * 63'(msf_pkg::RecipTen);
  end
  assign bound = rest_prod[msf_pkg::RecipShift +: BoundW];

  // Stretch stage.
  logic [31:0] len;
  logic d_neg_c;
  logic [31:0] d_dmag_c;
  logic [BoundW-1:0] d_cmag_c;
  logic d_vld, d_neg, d_short;
  msf_pkg::side_t d_side;
  logic [31:0] d_len, d_dmag;
  logic [BoundW-1:0] d_cmag;

  assign len = sq_r[SqSteps-1][31:0];

  always_comb begin
    d_neg_c = len < {1'b0, rest_length};
    d_dmag_c = d_neg_c ? ({1'b0, rest_length} - len) : (len - {1'b0, rest_length});
    d_cmag_c = (d_dmag_c > 32'(bound)) ? bound : d_dmag_c[BoundW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (adv) begin
      d_vld <= sq_vld[SqSteps-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_side <= sq_side[SqSteps-1];
      d_len <= len;
      d_neg <= d_neg_c;
      d_dmag <= d_dmag_c;
      d_cmag <= d_cmag_c;
      d_short <= len <= 32'(min_length);
    end
  end

  // Spring gain and correction numerators.
  msf_pkg::vec3_t d_smag;
  logic k_vld, k_neg, k_dzero, k_short;
  msf_pkg::side_t k_side;
  logic [31:0] k_len;
  logic [58:0] k_prod;
  logic [2:0][63:0] k_nprod;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_smag[i] = msf_pkg::abs32(d_side.sep[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_vld <= 1'b0;
    end else if (adv) begin
      k_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k_side <= d_side;
      k_len <= d_len;
      k_neg <= d_neg;
      k_dzero <= (d_dmag == '0);
      k_short <= d_short;
      k_prod <= 59'(spring_gain) * 59'(d_cmag);
      for (int i = 0; i < 3; i++) begin
        k_nprod[i] <= 64'(d_smag[i]) * 64'(d_dmag);
      end
    end
  end

  // Rounded, saturated spring magnitude.
  logic [63:0] k_rnd;
  logic [31:0] k_cap, k_smag;
  logic s_vld, s_neg, s_stretch_neg, s_dzero, s_short;
  msf_pkg::side_t s_side;
  logic [31:0] s_len, s_smag;
  logic [2:0][63:0] s_nprod;

  always_comb begin
    k_rnd = (64'(k_prod) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    k_cap = k_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    k_smag = (k_rnd >= 64'(k_cap)) ? k_cap : k_rnd[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= 1'b0;
    end else if (adv) begin
      s_vld <= k_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_side <= k_side;
      s_len <= k_len;
      s_smag <= k_smag;
      s_neg <= k_neg && (k_smag != '0);
      s_stretch_neg <= k_neg;
      s_dzero <= k_dzero;
      s_short <= k_short;
      s_nprod <= k_nprod;
    end
  end

  // Spring numerators and sideband for the divider.
  msf_pkg::vec3_t s_sepmag;
  bside_t s_bside;
  logic p_vld;
  logic [31:0] p_len;
  logic [2:0][63:0] p_pprod, p_nprod;
  bside_t p_bside;

  always_comb begin
    s_bside.damp_a = s_side.damp_a;
    s_bside.damp_b = s_side.damp_b;
    s_bside.s_neg = s_neg;
    s_bside.stretch_neg = s_stretch_neg;
    s_bside.dzero = s_dzero;
    s_bside.short_len = s_short;
    s_bside.pinned_a = s_side.pinned_a;
    s_bside.pinned_b = s_side.pinned_b;
    for (int i = 0; i < 3; i++) begin
      s_sepmag[i] = msf_pkg::abs32(s_side.sep[i]);
      s_bside.sep_neg[i] = s_side.sep[i][31];
      s_bside.sep_zero[i] = (s_side.sep[i] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (adv) begin
      p_vld <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_len <= s_len;
      p_bside <= s_bside;
      p_nprod <= s_nprod;
      for (int i = 0; i < 3; i++) begin
        p_pprod[i] <= 64'(s_smag) * 64'(s_sepmag[i]);
      end
    end
  end

  // Six divisions by the length: three spring lanes, three correction lanes.
  logic [msf_pkg::DivLanes-1:0][63:0] div_num;
  logic dv_valid;
  logic [$bits(bside_t)-1:0] dv_side_bits;
  bside_t fs;
  logic [31:0] dv_den;
  logic [msf_pkg::DivLanes-1:0][msf_pkg::QuoW-1:0] dv_quo;
  logic [msf_pkg::DivLanes-1:0][31:0] dv_rem;

  assign div_num = {p_nprod[2], p_nprod[1], p_nprod[0],
                    p_pprod[2], p_pprod[1], p_pprod[0]};

  msf_div #(
    .LANES (msf_pkg::DivLanes),
    .SIDE_W($bits(bside_t)),
    .NUM_W (64),
    .DEN_W (32),
    .QUO_W (msf_pkg::QuoW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (p_vld),
    .in_side  (p_bside),
    .num      (div_num),
    .den      (p_len),
    .out_valid(dv_valid),
    .out_side (dv_side_bits),
    .out_den  (dv_den),
    .quo      (dv_quo),
    .rem      (dv_rem)
  );

  assign fs = bside_t'(dv_side_bits);

  // Rounding, saturation and the pinned cases.
  logic [2:0] rup_s, rup_c, negfull;
  logic [2:0][33:0] rq_s, rq_c, hq_c;
  msf_pkg::vec3_t sp, full, half, neg_full, neg_half;
  msf_pkg::result_t res_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rup_s[i] = ({1'b0, dv_rem[i]} + {2'b0, dv_den[31:1]}) >= {1'b0, dv_den};
      rup_c[i] = ({1'b0, dv_rem[i+3]} + {2'b0, dv_den[31:1]}) >= {1'b0, dv_den};
      rq_s[i] = 34'(dv_quo[i]) + 34'(rup_s[i]);
      rq_c[i] = 34'(dv_quo[i+3]) + 34'(rup_c[i]);
      hq_c[i] = (34'(dv_quo[i+3]) + 34'd1) >> 1;
      sp[i] = fs.short_len ? '0
            : msf_pkg::sat_mag(64'(rq_s[i]), fs.s_neg ^ fs.sep_neg[i]);
      negfull[i] = ((!fs.sep_neg[i] && !fs.sep_zero[i]) != fs.stretch_neg)
                   && !fs.sep_zero[i] && !fs.dzero;
      full[i] = msf_pkg::sat_mag(64'(rq_c[i]), negfull[i]);
      half[i] = msf_pkg::sat_mag(64'(hq_c[i]), negfull[i]);
      neg_full[i] = msf_pkg::sat_sum(33'd0 - {full[i][31], full[i]});
      neg_half[i] = msf_pkg::sat_sum(33'd0 - {half[i][31], half[i]});
      res_next.force_a[i] = msf_pkg::sat_sum({fs.damp_a[i][31], fs.damp_a[i]}
                                             - {sp[i][31], sp[i]});
      res_next.force_b[i] = msf_pkg::sat_sum({fs.damp_b[i][31], fs.damp_b[i]}
                                             + {sp[i][31], sp[i]});
      if (fs.short_len || (fs.pinned_a && fs.pinned_b)) begin
        res_next.move_a[i] = '0;
        res_next.move_b[i] = '0;
      end else if (!fs.pinned_a && !fs.pinned_b) begin
        res_next.move_a[i] = half[i];
        res_next.move_b[i] = neg_half[i];
      end else if (!fs.pinned_a) begin
        res_next.move_a[i] = full[i];
        res_next.move_b[i] = '0;
      end else begin
        res_next.move_a[i] = '0;
        res_next.move_b[i] = neg_full[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= res_next;
    end
  end

endmodule

### sv/mass_spring_force_step_core.sv
// Top level of the mass-spring force step: configuration registers, front, queue and back.
`timescale 1ns / 1ps

// One spring per transaction in signed fixed point with FRAC_BITS fraction bits. The block
// accepts a new transaction every cycle unless back-pressure on out_ready fills the queue,
// and delivers one result per transaction, in order. The pipeline holds one front register,
// the two-entry queue, 32 square-root stages, four stages for the stretch clamp and
// products, 33 divider stages and the output register. The square root and the divider
// make up most of it. Configuration registers update at the write edge and the stretch
// clamp bound in the cycle after, so write them only while no transaction is in flight.

module mass_spring_force_step_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [msf_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [msf_pkg::GainW-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [31:0]            sep_x,
  input  logic signed [31:0]            sep_y,
  input  logic signed [31:0]            sep_z,
  input  logic signed [31:0]            vel_a_x,
  input  logic signed [31:0]            vel_a_y,
  input  logic signed [31:0]            vel_a_z,
  input  logic signed [31:0]            vel_b_x,
  input  logic signed [31:0]            vel_b_y,
  input  logic signed [31:0]            vel_b_z,
  input  logic                          pinned_a,
  input  logic                          pinned_b,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [31:0]            force_a_x,
  output logic signed [31:0]            force_a_y,
  output logic signed [31:0]            force_a_z,
  output logic signed [31:0]            force_b_x,
  output logic signed [31:0]            force_b_y,
  output logic signed [31:0]            force_b_z,
  output logic signed [31:0]            move_a_x,
  output logic signed [31:0]            move_a_y,
  output logic signed [31:0]            move_a_z,
  output logic signed [31:0]            move_b_x,
  output logic signed [31:0]            move_b_y,
  output logic signed [31:0]            move_b_z
);
  logic [msf_pkg::GainW-1:0] spring_gain, damping_gain, rest_length;
  logic [msf_pkg::MinW-1:0] min_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      spring_gain <= 31'd65536;
      damping_gain <= 31'd32768;
      rest_length <= 31'd65536;
      min_length <= 16'd1;
    end else if (cfg_write) begin
      case (msf_pkg::cfg_reg_t'(cfg_index))
        msf_pkg::REG_SPRING_GAIN: spring_gain <= cfg_data;
        msf_pkg::REG_DAMPING_GAIN: damping_gain <= cfg_data;
        msf_pkg::REG_REST_LENGTH: rest_length <= cfg_data;
        msf_pkg::REG_MIN_LENGTH: min_length <= cfg_data[msf_pkg::MinW-1:0];
        default: ;
      endcase
    end
  end

  logic f_push, q_full, q_empty, q_pop;
  msf_pkg::item_t f_item, q_item;
  msf_pkg::result_t result;

  msf_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sep         ({sep_z, sep_y, sep_x}),
    .vel_a       ({vel_a_z, vel_a_y, vel_a_x}),
    .vel_b       ({vel_b_z, vel_b_y, vel_b_x}),
    .pinned_a    (pinned_a),
    .pinned_b    (pinned_b),
    .damping_gain(damping_gain),
    .push        (f_push),
    .item        (f_item),
    .room        (!q_full)
  );

  msf_fifo #(
    .W    ($bits(msf_pkg::item_t)),
    .DEPTH(msf_pkg::FifoDepth)
  ) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (f_push),
    .wdata(f_item),
    .pop  (q_pop),
    .rdata(q_item),
    .full (q_full),
    .empty(q_empty)
  );

  msf_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (!q_empty),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .spring_gain(spring_gain),
    .rest_length(rest_length),
    .min_length (min_length),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result)
  );

  assign force_a_x = result.force_a[0];
  assign force_a_y = result.force_a[1];
  assign force_a_z = result.force_a[2];
  assign force_b_x = result.force_b[0];
  assign force_b_y = result.force_b[1];
  assign force_b_z = result.force_b[2];
  assign move_a_x = result.move_a[0];
  assign move_a_y = result.move_a[1];
  assign move_a_z = result.move_a[2];
  assign move_b_x = result.move_b[0];
  assign move_b_y = result.move_b[1];
  assign move_b_z = result.move_b[2];

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("Back half popped an empty queue.");

  a_front_not_blocked: assert property (@(posedge clk) disable iff (rst)
    !q_full |-> in_ready)
    else $error("Front half refused a transaction while the queue had room.");

  a_reset_clears_output: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result valid after reset.");

endmodule
